@@ sv/pps_pkg.sv @@
// shared types and constants for the pogo power mode sequencer
package pps_pkg;

    localparam int TIME_BITS = 16;
    localparam int DUR_W     = 16;
    localparam int CFG_W     = 16;
    localparam int EXT_W     = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

    localparam logic [CFG_W-1:0] DISCHARGE_RESET = CFG_W'(100);

    typedef logic [TIME_BITS-1:0] t_time;

    localparam t_time TIME_MAX = '1;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_IDLE   = 3'd1,
        REQ_CHARGE = 3'd2,
        REQ_COMM   = 3'd3,
        REQ_DISCH  = 3'd4,
        REQ_PULSE  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_CHARGE = 2'd1,
        MODE_COMM   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_BLEED = 2'd1,
        PH_DISCH = 2'd2,
        PH_PULSE = 2'd3
    } t_phase;

    typedef struct packed {
        logic  ldo;
        logic  route;
        logic  bleed;
        t_mode mode;
        logic  busy;
        logic  rej;
    } t_result;

endpackage

@@ sv/pps_in_reg.sv @@
// input register stage for request transactions
module pps_in_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [2:0]                 i_req,
    input  logic [pps_pkg::DUR_W-1:0]  i_dur,
    input  logic                       i_adv,
    output logic                       o_stall,
    output logic                       o_valid,
    output logic [2:0]                 o_req,
    output logic [pps_pkg::DUR_W-1:0]  o_dur
);
    import pps_pkg::*;

    logic             r_valid;
    logic [2:0]       r_req;
    logic [DUR_W-1:0] r_dur;

    assign o_stall = r_valid && !i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
            r_dur <= i_dur;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;
    assign o_dur   = r_dur;

endmodule

@@ sv/pps_seq.sv @@
// mode, phase and countdown state with the per-transaction update logic
module pps_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pps_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_commit,
    input  logic [2:0]                 i_req,
    input  logic [pps_pkg::DUR_W-1:0]  i_dur,
    output pps_pkg::t_result           o_res
);
    import pps_pkg::*;

    typedef struct packed {
        t_mode  mode;
        t_mode  saved;
        t_phase phase;
        t_time  rem;
        logic   ldo;
        logic   route;
        logic   bleed;
    } t_state;

    t_state           r_st;
    t_state           n_st;
    logic [CFG_W-1:0] r_dtk;
    logic             rej;
    logic             cmd;
    t_req             req;
    t_time            dt;
    t_time            dur;

    function automatic t_time f_sat(input logic [EXT_W-1:0] e);
        if (e > EXT_W'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return TIME_BITS'(e);
    endfunction

    function automatic t_state f_connect(input t_state s);
        t_state t;
        t = s;
        t.bleed = 1'b0;
        t.ldo   = 1'b1;
        t.route = 1'b1;
        t.mode  = MODE_COMM;
        t.phase = PH_NONE;
        return t;
    endfunction

    function automatic t_state f_start_comm(input t_state s, input t_time d);
        t_state t;
        t = s;
        t.bleed = 1'b1;
        t.rem   = d;
        t.phase = PH_BLEED;
        if (d == '0) begin
            t = f_connect(t);
        end
        return t;
    endfunction

    function automatic t_state f_restore(input t_state s, input t_mode m, input t_time d);
        t_state t;
        t = s;
        t.phase = PH_NONE;
        if (m == MODE_COMM) begin
            t = f_start_comm(t, d);
        end else begin
            t.ldo   = 1'b0;
            t.route = 1'b0;
            t.bleed = 1'b0;
            t.mode  = (m == MODE_CHARGE) ? MODE_CHARGE : MODE_IDLE;
        end
        return t;
    endfunction

    function automatic t_state f_phase_done(input t_state s, input t_time d);
        t_state t;
        t = s;
        unique case (s.phase)
            PH_BLEED: t = f_connect(s);
            PH_DISCH: begin
                t.bleed = 1'b0;
                t.phase = PH_NONE;
            end
            PH_PULSE: t = f_restore(s, s.saved, d);
            default:  t.phase = PH_NONE;
        endcase
        return t;
    endfunction

    assign req = t_req'(i_req);
    assign dt  = f_sat(EXT_W'(r_dtk));
    assign dur = f_sat(EXT_W'(i_dur));
    assign cmd = (req != REQ_TICK) && (i_req <= REQ_PULSE);

    always_comb begin
        n_st = r_st;
        rej  = 1'b0;
        if (req == REQ_TICK) begin
            if (r_st.phase != PH_NONE) begin
                if (r_st.rem != '0) begin
                    n_st.rem = r_st.rem - 1'b1;
                end
                if (n_st.rem == '0) begin
                    n_st = f_phase_done(n_st, dt);
                end
            end
        end else if (cmd && r_st.phase != PH_NONE) begin
            rej = 1'b1;
        end else if (cmd) begin
            unique case (req)
                REQ_IDLE: begin
                    n_st.ldo   = 1'b0;
                    n_st.route = 1'b0;
                    n_st.bleed = 1'b0;
                    n_st.mode  = MODE_IDLE;
                end
                REQ_CHARGE: begin
                    n_st.ldo   = 1'b0;
                    n_st.route = 1'b0;
                    n_st.bleed = 1'b0;
                    n_st.mode  = MODE_CHARGE;
                end
                REQ_COMM: n_st = f_start_comm(r_st, dt);
                REQ_DISCH: begin
                    n_st.bleed = 1'b1;
                    n_st.rem   = dur;
                    n_st.phase = PH_DISCH;
                    if (dur == '0) begin
                        n_st = f_phase_done(n_st, dt);
                    end
                end
                REQ_PULSE: begin
                    n_st.saved = r_st.mode;
                    n_st.ldo   = 1'b0;
                    n_st.route = 1'b0;
                    n_st.bleed = 1'b0;
                    n_st.mode  = MODE_CHARGE;
                    n_st.rem   = dur;
                    n_st.phase = PH_PULSE;
                    if (dur == '0) begin
                        n_st = f_phase_done(n_st, dt);
                    end
                end
                default: n_st = r_st;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode  <= MODE_IDLE;
            r_st.saved <= MODE_IDLE;
            r_st.phase <= PH_NONE;
            r_st.rem   <= '0;
            r_st.ldo   <= 1'b0;
            r_st.route <= 1'b0;
            r_st.bleed <= 1'b0;
        end else if (i_commit) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtk <= DISCHARGE_RESET;
        end else if (i_cfg_we) begin
            r_dtk <= i_cfg_wdata;
        end
    end

    always_comb begin
        o_res.ldo   = n_st.ldo;
        o_res.route = n_st.route;
        o_res.bleed = n_st.bleed;
        o_res.mode  = n_st.mode;
        o_res.busy  = (n_st.phase != PH_NONE);
        o_res.rej   = rej;
    end

endmodule

@@ sv/pps_out_reg.sv @@
// result register stage for status transactions
module pps_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pps_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output pps_pkg::t_result o_res
);
    import pps_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ sv/pogo_power_mode_sequencer_core.sv @@
// top level of the pogo power mode sequencer
// an accepted request goes through the input register, then the result register
// throughput: one transaction per cycle unless stalled, set by the single state update step
// the input and result registers each hold one transaction while downstream stalls
// reset (synchronous, active low) empties both stages, clears mode, phase, countdown
// and pins, and sets the discharge time to 100 ticks
module pogo_power_mode_sequencer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pps_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_req_type,
    input  logic [pps_pkg::DUR_W-1:0]  i_duration_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_ldo_enable,
    output logic                       o_uart_route,
    output logic                       o_bleed_enable,
    output logic [1:0]                 o_mode_now,
    output logic                       o_busy_res,
    output logic                       o_rejected
);
    import pps_pkg::*;

    logic             s1_valid;
    logic [2:0]       s1_req;
    logic [DUR_W-1:0] s1_dur;
    logic             s2_ready;
    t_result          step_res;
    t_result          out_res;

    pps_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_req   (i_req_type),
        .i_dur   (i_duration_ms),
        .i_adv   (s2_ready),
        .o_stall (o_in_stall),
        .o_valid (s1_valid),
        .o_req   (s1_req),
        .o_dur   (s1_dur)
    );

    pps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_commit    (s1_valid && s2_ready),
        .i_req       (s1_req),
        .i_dur       (s1_dur),
        .o_res       (step_res)
    );

    pps_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_res   (step_res),
        .i_stall (i_out_stall),
        .o_ready (s2_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_ldo_enable   = out_res.ldo;
    assign o_uart_route   = out_res.route;
    assign o_bleed_enable = out_res.bleed;
    assign o_mode_now     = out_res.mode;
    assign o_busy_res     = out_res.busy;
    assign o_rejected     = out_res.rej;

endmodule

@@ sv/pps_checker.sv @@
// port-level checks for the pogo power mode sequencer, bound to the top level
module pps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_ldo_enable,
    input logic                       o_uart_route,
    input logic [1:0]                 o_mode_now,
    input logic                       o_busy_res,
    input logic                       o_rejected
);
    import pps_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mode_now))
        else $error("stalled transaction dropped or changed");

    a_switch_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_uart_route == o_ldo_enable)
        else $error("regulator and switch disagree");

    a_route_comm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_uart_route |-> o_mode_now == MODE_COMM)
        else $error("uart path connected outside comm mode");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res)
        else $error("rejection without a timed phase");

endmodule

bind pogo_power_mode_sequencer_core pps_checker u_pps_checker (.*);
